// ===== src/leader_cluster_assign_defines.svh =====
// ----------------------------------------------------------------------------
// Leader cluster assignment: assertion macros
// Shared macros for the concurrent checks of the clustering block.
// ----------------------------------------------------------------------------
`ifndef LEADER_CLUSTER_ASSIGN_DEFINES_SVH
`define LEADER_CLUSTER_ASSIGN_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lca_pkg.sv =====
// ----------------------------------------------------------------------------
// Leader cluster assignment package
// Widths, reset values, payload structs and the controller state type.
// ----------------------------------------------------------------------------
package lca_pkg;

  // Coordinate width of a point (signed Q8.8).
  localparam int unsigned COORD_W          = 16;
  // Width of the squared radius register (unsigned Q19.16).
  localparam int unsigned RAD_W            = 35;
  // Width of the reported cluster index.
  localparam int unsigned IDX_OUT_W        = 6;
  // Default depth of the centroid table.
  localparam int unsigned DEF_MAX_CLUSTERS = 64;
  // Squared radius after reset: 1.0 in Q19.16.
  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(65536);

  // One input transaction.
  typedef struct packed {
    logic                      first_of_set;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } lca_in_t;

  // One result transaction.
  typedef struct packed {
    logic [IDX_OUT_W-1:0] cluster_index;
    logic                 is_new_cluster;
    logic                 table_overflow;
  } lca_out_t;

  // A stored centroid, also used for the point under test.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } lca_centroid_t;

  // Control from the sequencer to the distance unit.
  typedef struct packed {
    logic vld;
    logic flush;
  } lca_dist_ctl_t;

  // Status from the distance unit back to the sequencer.
  typedef struct packed {
    logic vld;
    logic hit;
  } lca_dist_sts_t;

  // Sequencer states.
  typedef enum logic {
    LCA_IDLE,
    LCA_SCAN
  } lca_state_e;

endpackage

// ===== src/leader_cluster_assign.sv =====
// A scan compares the stored centroids in creation order and ends at the first
// hit, or on a miss once every stored centroid has been compared; with an empty
// table it ends with a miss. A new point is accepted only while idle; the single
// read port of the centroid memory serves one centroid per cycle.
// Reset clears the centroid count and sets the squared radius to 1.0 (Q19.16);
// the centroid memory is not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// Leader cluster assignment
// Matches each point against stored centroids in creation order and reports
// the first cluster within the radius, else adds it as a new one (overflow if full).
// ----------------------------------------------------------------------------
`include "leader_cluster_assign_defines.svh"

module leader_cluster_assign #(
  parameter int unsigned MAX_CLUSTERS = lca_pkg::DEF_MAX_CLUSTERS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  lca_pkg::lca_in_t          item_i,
  output logic                      done_o,
  output lca_pkg::lca_out_t         result_o,
  input  logic                      cfg_we_i,
  input  logic [lca_pkg::RAD_W-1:0] cfg_wdata_i
);
  import lca_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_CLUSTERS);
  localparam int unsigned CNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_CLUSTERS);

  lca_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [RAD_W-1:0] radius_q;
  lca_centroid_t    pt_q;
  logic             done_q;
  lca_out_t         res_q, res_d;

  logic             accept;
  logic             rd_en;
  logic             fin;
  logic             fin_hit;
  logic             table_full;
  logic             mem_we;
  lca_centroid_t    mem_rdata;
  lca_dist_ctl_t    dctl;
  lca_dist_sts_t    dsts;
  logic [IDX_W-1:0] didx;
  logic [IDX_W+IDX_OUT_W-1:0] hit_idx_ext;
  logic [IDX_W+IDX_OUT_W-1:0] new_idx_ext;

  assign accept     = start_i && (state_q == LCA_IDLE);
  assign table_full = (count_q == CNT_FULL);
  assign busy_o     = (state_q != LCA_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LCA_IDLE: begin
        if (start_i) begin
          state_d = LCA_SCAN;
        end
      end
      LCA_SCAN: begin
        if (fin) begin
          state_d = LCA_IDLE;
        end
      end
      default: state_d = LCA_IDLE;
    endcase
  end

  // Sequencer outputs: issue reads in order, finish on the first hit or
  // once every stored centroid has been compared.
  always_comb begin
    rd_en   = 1'b0;
    fin     = 1'b0;
    fin_hit = 1'b0;
    unique case (state_q)
      LCA_IDLE: begin
      end
      LCA_SCAN: begin
        if (dsts.vld && dsts.hit) begin
          fin     = 1'b1;
          fin_hit = 1'b1;
        end else if ((issue_q == count_q) && !rd_vld_q && !dsts.vld) begin
          fin = 1'b1;
        end else begin
          rd_en = (issue_q < count_q);
        end
      end
      default: begin
      end
    endcase
  end

  // A miss with room appends the point. The write lands at the finishing
  // edge, before any read of the next transaction can be issued.
  assign mem_we = fin && !fin_hit && !table_full;

  // Count and read pointer.
  always_comb begin
    count_d = count_q;
    issue_d = issue_q;
    if (accept) begin
      issue_d = '0;
      if (item_i.first_of_set) begin
        count_d = '0;
      end
    end else begin
      if (rd_en) begin
        issue_d = issue_q + CNT_W'(1);
      end
      if (mem_we) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  // Result word.
  always_comb begin
    hit_idx_ext = {{IDX_OUT_W{1'b0}}, didx};
    new_idx_ext = {{IDX_OUT_W{1'b0}}, count_q[IDX_W-1:0]};
    res_d       = res_q;
    if (fin) begin
      if (fin_hit) begin
        res_d.cluster_index  = hit_idx_ext[IDX_OUT_W-1:0];
        res_d.is_new_cluster = 1'b0;
        res_d.table_overflow = 1'b0;
      end else if (table_full) begin
        res_d.cluster_index  = '0;
        res_d.is_new_cluster = 1'b0;
        res_d.table_overflow = 1'b1;
      end else begin
        res_d.cluster_index  = new_idx_ext[IDX_OUT_W-1:0];
        res_d.is_new_cluster = 1'b1;
        res_d.table_overflow = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= LCA_IDLE;
      count_q  <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
      radius_q <= RADIUS_RESET;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_en;
      done_q   <= fin;
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q.x <= item_i.coord_x;
      pt_q.y <= item_i.coord_y;
    end
    if (rd_en) begin
      rd_idx_q <= issue_q[IDX_W-1:0];
    end
    res_q <= res_d;
  end

  // Centroid storage.
  lca_centroid_mem #(
    .DEPTH  (MAX_CLUSTERS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (pt_q),
    .re_i    (rd_en),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  // Distance compare; in-flight compares are dropped when a transaction ends.
  assign dctl.vld   = rd_vld_q;
  assign dctl.flush = fin;

  lca_dist_unit #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (dctl),
    .idx_i    (rd_idx_q),
    .cent_i   (mem_rdata),
    .pt_i     (pt_q),
    .radius_i (radius_q),
    .sts_o    (dsts),
    .idx_o    (didx)
  );

  assign done_o   = done_q;
  assign result_o = res_q;

  // Checks.
  `LCA_ASSERT_NXT(a_accept_busy, accept, busy_o, "accepted transaction did not start a scan")
  `LCA_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_FULL, "centroid count above table size")
  `LCA_ASSERT_IMP(a_res_excl, done_o, !(result_o.is_new_cluster && result_o.table_overflow), "new cluster and overflow together")
  `LCA_ASSERT_IMP(a_ovf_full, done_o && result_o.table_overflow, table_full, "overflow with free table entries")

endmodule

// ===== src/lca_centroid_mem.sv =====
// ----------------------------------------------------------------------------
// Centroid memory
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lca_centroid_mem #(
  parameter int unsigned DEPTH = lca_pkg::DEF_MAX_CLUSTERS,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  lca_pkg::lca_centroid_t wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output lca_pkg::lca_centroid_t rdata_o
);
  import lca_pkg::*;

  lca_centroid_t mem_q [DEPTH];
  lca_centroid_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lca_dist_unit.sv =====
// ----------------------------------------------------------------------------
// Distance unit
// Squares the coordinate differences of a centroid and the point, registers
// them, then sums and compares the result against the squared radius.
// ----------------------------------------------------------------------------
module lca_dist_unit #(
  parameter int unsigned IDX_W = $clog2(lca_pkg::DEF_MAX_CLUSTERS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lca_pkg::lca_dist_ctl_t    ctl_i,
  input  logic [IDX_W-1:0]          idx_i,
  input  lca_pkg::lca_centroid_t    cent_i,
  input  lca_pkg::lca_centroid_t    pt_i,
  input  logic [lca_pkg::RAD_W-1:0] radius_i,
  output lca_pkg::lca_dist_sts_t    sts_o,
  output logic [IDX_W-1:0]          idx_o
);
  import lca_pkg::*;

  localparam int unsigned SQ_W   = 2 * COORD_W;
  localparam int unsigned SUM_W  = SQ_W + 1;
  localparam int unsigned CMP_W  = (SUM_W > RAD_W) ? SUM_W : RAD_W;
  localparam int unsigned PROD_W = 2 * COORD_W + 2;

  logic signed [COORD_W:0]     dx, dy;
  logic signed [PROD_W-1:0]    px, py;
  logic [SQ_W-1:0]             sq_x_q, sq_y_q;
  logic                        vld_q;
  logic [IDX_W-1:0]            idx_q;
  logic [SUM_W-1:0]            sum;

  // Differences and squares; a difference never exceeds 2^COORD_W - 1 in
  // magnitude, so its square fits in SQ_W bits.
  always_comb begin
    dx = {cent_i.x[COORD_W-1], cent_i.x} - {pt_i.x[COORD_W-1], pt_i.x};
    dy = {cent_i.y[COORD_W-1], cent_i.y} - {pt_i.y[COORD_W-1], pt_i.y};
    px = PROD_W'(dx) * PROD_W'(dx);
    py = PROD_W'(dy) * PROD_W'(dy);
  end

  // Square registers.
  always_ff @(posedge clk_i) begin
    sq_x_q <= px[SQ_W-1:0];
    sq_y_q <= py[SQ_W-1:0];
    idx_q  <= idx_i;
  end

  // Valid flag, cleared when the sequencer finishes a transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctl_i.vld && !ctl_i.flush;
    end
  end

  // Sum and radius compare.
  always_comb begin
    sum       = {1'b0, sq_x_q} + {1'b0, sq_y_q};
    sts_o.vld = vld_q;
    sts_o.hit = CMP_W'(sum) <= CMP_W'(radius_i);
  end

  assign idx_o = idx_q;

endmodule

// ===== sim/lca_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Leader cluster assignment scoreboard
// Keeps its own centroid table and squared radius, works out the cluster
// assignment for every accepted point and compares the block's results with
// those assignments in order.
// ----------------------------------------------------------------------------
package lca_tb_pkg;
  import lca_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEF_MAX_CLUSTERS;

  class cluster_scoreboard;
    lca_centroid_t    centroids [TABLE_DEPTH];
    int unsigned      n_clusters;
    logic [RAD_W-1:0] radius_sq;
    lca_out_t         pending_assignments [$];
    int unsigned      results_seen;
    int unsigned      mismatches;

    function new();
      n_clusters   = 0;
      radius_sq    = RADIUS_RESET;
      results_seen = 0;
      mismatches   = 0;
    endfunction

    function void set_radius(input logic [RAD_W-1:0] value);
      radius_sq = value;
    endfunction

    function int unsigned pending();
      return pending_assignments.size();
    endfunction

    // First centroid within the radius wins; a miss appends the point unless
    // the table is full, in which case only the overflow flag is raised.
    function lca_out_t predict_assignment(input lca_in_t p);
      lca_out_t res;
      longint   dx;
      longint   dy;
      longint   dist_sq;
      res = '0;
      if (p.first_of_set) n_clusters = 0;
      for (int k = 0; k < n_clusters; k++) begin
        dx      = longint'($signed(centroids[k].x)) - longint'($signed(p.coord_x));
        dy      = longint'($signed(centroids[k].y)) - longint'($signed(p.coord_y));
        dist_sq = dx * dx + dy * dy;
        if (dist_sq <= longint'({29'd0, radius_sq})) begin
          res.cluster_index = IDX_OUT_W'(k);
          return res;
        end
      end
      if (n_clusters >= TABLE_DEPTH) begin
        res.table_overflow = 1'b1;
        return res;
      end
      centroids[n_clusters].x = p.coord_x;
      centroids[n_clusters].y = p.coord_y;
      res.cluster_index  = IDX_OUT_W'(n_clusters);
      res.is_new_cluster = 1'b1;
      n_clusters++;
      return res;
    endfunction

    // Called for every accepted input transaction.
    function void note_point(input lca_in_t p);
      pending_assignments.push_back(predict_assignment(p));
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      $display("ERROR %0t: %s", $time, msg);
    endtask

    // Called for every result transaction; compares against the oldest
    // outstanding assignment.
    task check_result(input lca_out_t got);
      lca_out_t exp;
      results_seen++;
      if (pending_assignments.size() == 0) begin
        report_mismatch($sformatf("result %0d with no point outstanding: index %0d new %b ovf %b",
                                  results_seen, got.cluster_index, got.is_new_cluster,
                                  got.table_overflow));
        return;
      end
      exp = pending_assignments.pop_front();
      if (got.cluster_index !== exp.cluster_index)
        report_mismatch($sformatf("result %0d cluster_index %0d, expected %0d",
                                  results_seen, got.cluster_index, exp.cluster_index));
      if (got.is_new_cluster !== exp.is_new_cluster)
        report_mismatch($sformatf("result %0d is_new_cluster %b, expected %b",
                                  results_seen, got.is_new_cluster, exp.is_new_cluster));
      if (got.table_overflow !== exp.table_overflow)
        report_mismatch($sformatf("result %0d table_overflow %b, expected %b",
                                  results_seen, got.table_overflow, exp.table_overflow));
    endtask
  endclass

endpackage

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Leader cluster assignment testbench
// Drives directed and random point sets through the clustering block under
// several squared radii, with random gaps between transactions, and checks
// every result against the scoreboard's predicted assignment.
// ----------------------------------------------------------------------------
module tb;
  import lca_pkg::*;
  import lca_tb_pkg::*;

  localparam logic [RAD_W-1:0] RADIUS_MAX  = '1;
  localparam int unsigned      STALL_LIMIT = 2000;
  localparam int unsigned      NUM_PHASES  = 10;
  localparam int unsigned      PHASE_ITEMS = 85;
  localparam int unsigned      RECENT_KEEP = 16;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start_i     = 1'b0;
  logic             busy_o;
  lca_in_t          item_i      = '0;
  logic             done_o;
  lca_out_t         result_o;
  logic             cfg_we_i    = 1'b0;
  logic [RAD_W-1:0] cfg_wdata_i = '0;

  cluster_scoreboard sb = new();
  lca_in_t           recent_pts [$];
  bit                no_idle = 1'b0;
  int unsigned       quiet_cycles = 0;

  leader_cluster_assign dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Results are checked before the input of the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) sb.check_result(result_o);
      if (start_i && busy_o === 1'b0) sb.note_point(item_i);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || done_o === 1'b1 || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("leader_cluster_assign test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  function automatic lca_in_t mk_point(input bit first, input int x, input int y);
    lca_in_t p;
    p.first_of_set = first;
    p.coord_x      = x[COORD_W-1:0];
    p.coord_y      = y[COORD_W-1:0];
    return p;
  endfunction

  // Mix of points near recent ones, exact repeats, corners and random values.
  function automatic lca_in_t random_point(input bit first);
    int          corners [5] = '{-32768, -1, 0, 1, 32767};
    int unsigned mode;
    int          x;
    int          y;
    lca_in_t     base;
    mode = $urandom_range(0, 9);
    if (recent_pts.size() == 0 && mode < 4) mode = 4;
    if (recent_pts.size() != 0) base = recent_pts[$urandom_range(0, recent_pts.size() - 1)];
    case (mode)
      0, 1, 2: begin
        x = int'($signed(base.coord_x)) + int'($urandom_range(0, 600)) - 300;
        y = int'($signed(base.coord_y)) + int'($urandom_range(0, 600)) - 300;
      end
      3: begin
        x = int'($signed(base.coord_x));
        y = int'($signed(base.coord_y));
      end
      4, 5: begin
        x = $urandom;
        y = $urandom;
      end
      6: begin
        x = corners[$urandom_range(0, 4)];
        y = corners[$urandom_range(0, 4)];
      end
      default: begin
        x = int'($urandom_range(0, 2047)) - 1024;
        y = int'($urandom_range(0, 2047)) - 1024;
      end
    endcase
    return mk_point(first, x, y);
  endfunction

  // Presents one point after a gap and returns at the edge that accepts it.
  task automatic send_point(input lca_in_t p, input int unsigned gap);
    lca_in_t noise;
    if (gap != 0) begin
      noise.first_of_set = 1'($urandom);
      noise.coord_x      = 16'($urandom);
      noise.coord_y      = 16'($urandom);
      start_i <= 1'b0;
      item_i  <= noise;
      repeat (gap) @(posedge clk_i);
    end
    item_i  <= p;
    start_i <= 1'b1;
    do @(posedge clk_i); while (!(start_i && busy_o === 1'b0));
    recent_pts.push_back(p);
    if (recent_pts.size() > RECENT_KEEP) void'(recent_pts.pop_front());
  endtask

  // Holds off new points until every outstanding result has come back.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 || busy_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [RAD_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_radius(value);
  endtask

  initial begin
    logic [RAD_W-1:0] rad;
    int unsigned      phase_items;
    int unsigned      set_len;
    bit               first;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset radius of 1.0 (256 units per axis).
    send_point(mk_point(1'b1, 0, 0), pick_gap());
    send_point(mk_point(1'b0, 0, 0), pick_gap());
    send_point(mk_point(1'b0, 256, 0), pick_gap());       // exactly on the radius
    send_point(mk_point(1'b0, 0, -256), pick_gap());
    send_point(mk_point(1'b0, 257, 0), pick_gap());       // just outside
    send_point(mk_point(1'b0, 181, 181), pick_gap());
    send_point(mk_point(1'b0, -32768, -32768), pick_gap());
    send_point(mk_point(1'b0, 32767, 32767), pick_gap());
    send_point(mk_point(1'b0, 32767, -32768), pick_gap());
    send_point(mk_point(1'b0, -32768, 32767), pick_gap());
    send_point(mk_point(1'b0, -1, -1), pick_gap());
    // A new set empties the table.
    send_point(mk_point(1'b1, 32767, 32767), pick_gap());
    send_point(mk_point(1'b0, -32768, -32768), pick_gap());

    // Largest radius: even opposite corners fall in the first cluster.
    drain();
    write_radius(RADIUS_MAX);
    send_point(mk_point(1'b0, 0, 0), pick_gap());
    send_point(mk_point(1'b0, -32768, -32768), pick_gap());

    // Zero radius: only exact repeats match.
    drain();
    write_radius('0);
    send_point(mk_point(1'b1, 100, -100), pick_gap());
    send_point(mk_point(1'b0, 100, -100), pick_gap());
    send_point(mk_point(1'b0, 101, -100), pick_gap());

    // Random point sets, one squared radius per phase.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase % 5)
        0:       rad = '0;
        1:       rad = RAD_W'($urandom_range(0, 32'h0010_0000));
        2:       rad = RADIUS_MAX;
        3:       rad = {3'($urandom), $urandom};
        default: rad = RAD_W'($urandom_range(32'h0001_0000, 32'h0100_0000));
      endcase
      write_radius(rad);
      no_idle = (phase % 4 == 3);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // Long sets fill the table so that overflow is reached.
        set_len = ($urandom_range(0, 99) < 20) ? $urandom_range(60, 90)
                                               : $urandom_range(1, 24);
        for (int i = 0; i < set_len; i++) begin
          if (i == 0) first = ($urandom_range(0, 9) != 0);
          else first = ($urandom_range(0, 99) < 4);
          send_point(random_point(first), pick_gap());
        end
        phase_items += set_len;
      end
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("leader_cluster_assign test passed");
    end else begin
      $display("leader_cluster_assign test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/lca_pkg.sv
src/lca_centroid_mem.sv
src/lca_dist_unit.sv
src/leader_cluster_assign.sv
sim/lca_tb_pkg.sv
sim/tb.sv
